### hdl/assert_macros.svh
// Assertion macros included by the interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CMI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CMI_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CMI_ASSERT(lbl, clk, rst, prop, msg)
`define CMI_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

### hdl/cmi_pkg.sv
// Package with the types and constants of the colour map interpolator.
`default_nettype none
package cmi_pkg;
   localparam int MAX_KEYS  = 8;
   localparam int IDX_W     = $clog2(MAX_KEYS);
   localparam int CNT_W     = $clog2(MAX_KEYS + 1);
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 16;
   localparam int DIV_W     = 32;
   localparam int DEN_W     = 16;
   localparam int S_W       = 34;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;
   localparam logic [1:0] CMD_NOP    = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_EN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_EN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER    = 2'd3;

   localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] key_position;
      logic [7:0]         key_red;
      logic [7:0]         key_green;
      logic [7:0]         key_blue;
      logic [7:0]         key_alpha;
      logic signed [15:0] sample_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic [1:0] status;
   } rsp_type;
endpackage
`default_nettype wire

### hdl/color_map_interpolator_unit.sv
// Colour map interpolator: sorted key table, rescaling and per-channel blending.
//
// Items enter on the req_ channel (valid/ready) and one result item leaves on
// the rsp_ channel for every accepted item. The block works on one item at a
// time and drops req_ready while busy. A clear, an ignored command or a lookup
// on an empty table goes straight to the emit step; an insert first scans the
// sorted keys one at a time (up to MAX_KEYS). In a lookup, one 32-step serial
// divider runs once for the rescaling (only with an override enabled) and once
// for the interpolation fraction, the table is scanned one key a cycle, and one
// multiplier blends the four channels one after another.
// The result sits in an output register; the next item is accepted while it
// waits, and a new result waits in the sequencer until the receiver takes the
// old one, so a stalled receiver stalls the block without losing items.
// Synchronous reset empties the table, sets the override registers to their
// defaults and drops rsp_valid. The user must write the override registers
// through the csr_ port only while idle; the block does not enforce this.
`default_nettype none
module color_map_interpolator_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire cmi_pkg::req_type                  req_data,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      cmi_pkg::rsp_type                  rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [cmi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [cmi_pkg::CSR_W-1:0]         csr_wdata
);
   import cmi_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [3:0] {
      ST_IDLE, ST_INS_SCAN, ST_LK_FIRST, ST_LK_LAST, ST_LK_MUL, ST_LK_DIV1,
      ST_LK_RESC, ST_LK_CHECK, ST_LK_SCAN, ST_LK_DIV2, ST_LK_BLEND, ST_EMIT
   } state_type;

   state_type          state_ff;
   req_type            req_ff;
   logic               lower_en_ff, upper_en_ff;
   logic signed [15:0] lower_ff, upper_ff;
   logic signed [15:0] pos_ff [MAX_KEYS];
   logic [31:0]        col_ff [MAX_KEYS];
   logic [CNT_W-1:0]   count_ff, idx_ff;
   logic signed [15:0] pf_ff, plast_ff, prev_pos_ff;
   logic [31:0]        prev_col_ff, ca_ff, cb_ff, res_col_ff;
   logic [1:0]         res_status_ff;
   logic signed [16:0] samp_off_ff, diff_ff;
   logic               neg_ff;
   logic signed [S_W-1:0] s_ff;
   logic [DEN_W-1:0]   div_rem_ff, div_den_ff;
   logic [DIV_W-1:0]   div_quo_ff;
   logic [4:0]         div_cnt_ff;
   logic [1:0]         ch_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic signed [15:0] rd_pos;
   logic [31:0]        rd_col;
   logic signed [16:0] lo17, hi17, span17, den17;
   logic signed [33:0] prod34;
   logic [33:0]        prod_mag;
   logic [16:0]        diff_mag;
   logic [16:0]        rem_sh;
   logic [17:0]        trial;
   logic [DEN_W-1:0]   div_rem_in;
   logic [DIV_W-1:0]   div_quo_in;
   logic [S_W-1:0]     q_ext;
   logic signed [S_W-1:0] s_in, rd_pos_ext, sp_diff;
   logic signed [8:0]  ch_delta;
   logic signed [16:0] t_ext;
   logic signed [25:0] blend_prod, blend_sum;
   logic [7:0]         ca_ch;
   logic               out_free;

   assign rd_pos     = pos_ff[idx_ff[IDX_W-1:0]];
   assign rd_col     = col_ff[idx_ff[IDX_W-1:0]];
   assign rd_pos_ext = S_W'(rd_pos);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      lo17 = lower_en_ff ? {lower_ff[15], lower_ff} : {pf_ff[15], pf_ff};
      hi17 = upper_en_ff ? {upper_ff[15], upper_ff} : {rd_pos[15], rd_pos};
      span17 = {plast_ff[15], plast_ff} - {pf_ff[15], pf_ff};
      prod34 = samp_off_ff * span17;
      prod_mag = prod34[33] ? 34'(-prod34) : 34'(prod34);
      diff_mag = diff_ff[16] ? 17'(-diff_ff) : 17'(diff_ff);
      rem_sh = {div_rem_ff, div_quo_ff[DIV_W-1]};
      trial = {1'b0, rem_sh} - {2'b00, div_den_ff};
      if (!trial[17]) begin
         div_rem_in = trial[DEN_W-1:0];
         div_quo_in = {div_quo_ff[DIV_W-2:0], 1'b1};
      end else begin
         div_rem_in = rem_sh[DEN_W-1:0];
         div_quo_in = {div_quo_ff[DIV_W-2:0], 1'b0};
      end
      q_ext = {2'b00, div_quo_ff};
      s_in = S_W'(pf_ff) + (neg_ff ? S_W'(-q_ext) : S_W'(q_ext));
      sp_diff = s_ff - S_W'(prev_pos_ff);
      den17 = {rd_pos[15], rd_pos} - {prev_pos_ff[15], prev_pos_ff};
      ca_ch = ca_ff[ch_ff*8 +: 8];
      ch_delta = $signed({1'b0, cb_ff[ch_ff*8 +: 8]}) - $signed({1'b0, ca_ch});
      t_ext = $signed({1'b0, div_quo_ff[15:0]});
      blend_prod = ch_delta * t_ext;
      blend_sum = $signed({2'b00, ca_ch, 16'h0000}) + blend_prod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         lower_en_ff <= 1'b0;
         lower_ff <= '0;
         upper_en_ff <= 1'b0;
         upper_ff <= 16'sd256;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LOWER_EN: lower_en_ff <= csr_wdata[0];
               CSR_LOWER:    lower_ff <= csr_wdata;
               CSR_UPPER_EN: upper_en_ff <= csr_wdata[0];
               CSR_UPPER:    upper_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  idx_ff <= '0;
                  res_col_ff <= '0;
                  res_status_ff <= STATUS_OK;
                  state_ff <= ST_EMIT;
                  case (req_data.cmd)
                     CMD_CLEAR:  count_ff <= '0;
                     CMD_INSERT: state_ff <= ST_INS_SCAN;
                     CMD_LOOKUP: begin
                        if (count_ff == '0) begin
                           res_col_ff <= OPAQUE_BLACK;
                           res_status_ff <= STATUS_EMPTY;
                        end else begin
                           state_ff <= ST_LK_FIRST;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_INS_SCAN: begin
               if (idx_ff < count_ff && rd_pos < req_ff.key_position) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  state_ff <= ST_EMIT;
                  if (idx_ff < count_ff && rd_pos == req_ff.key_position) begin
                     col_ff[idx_ff[IDX_W-1:0]] <= {req_ff.key_alpha, req_ff.key_blue,
                                                   req_ff.key_green, req_ff.key_red};
                  end else if (count_ff == CNT_W'(MAX_KEYS)) begin
                     res_status_ff <= STATUS_FULL;
                  end else begin
                     for (int j = 1; j < MAX_KEYS; j++) begin
                        if (CNT_W'(j) > idx_ff) begin
                           pos_ff[j] <= pos_ff[j-1];
                           col_ff[j] <= col_ff[j-1];
                        end
                     end
                     pos_ff[idx_ff[IDX_W-1:0]] <= req_ff.key_position;
                     col_ff[idx_ff[IDX_W-1:0]] <= {req_ff.key_alpha, req_ff.key_blue,
                                                   req_ff.key_green, req_ff.key_red};
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            ST_LK_FIRST: begin
               pf_ff <= rd_pos;
               prev_pos_ff <= rd_pos;
               prev_col_ff <= rd_col;
               if (count_ff == CNT_W'(1)) begin
                  res_col_ff <= rd_col;
                  state_ff <= ST_EMIT;
               end else begin
                  idx_ff <= count_ff - 1'b1;
                  state_ff <= ST_LK_LAST;
               end
            end
            ST_LK_LAST: begin
               plast_ff <= rd_pos;
               if (lower_en_ff || upper_en_ff) begin
                  if (lo17 == hi17) begin
                     res_col_ff <= prev_col_ff;
                     state_ff <= ST_EMIT;
                  end else begin
                     samp_off_ff <= {req_ff.sample_value[15], req_ff.sample_value} - lo17;
                     diff_ff <= hi17 - lo17;
                     state_ff <= ST_LK_MUL;
                  end
               end else begin
                  s_ff <= S_W'(req_ff.sample_value);
                  state_ff <= ST_LK_CHECK;
               end
            end
            ST_LK_MUL: begin
               neg_ff <= prod34[33] ^ diff_ff[16];
               div_quo_ff <= prod_mag[DIV_W-1:0];
               div_den_ff <= diff_mag[DEN_W-1:0];
               div_rem_ff <= '0;
               div_cnt_ff <= '0;
               state_ff <= ST_LK_DIV1;
            end
            ST_LK_DIV1, ST_LK_DIV2: begin
               div_rem_ff <= div_rem_in;
               div_quo_ff <= div_quo_in;
               div_cnt_ff <= div_cnt_ff + 1'b1;
               ch_ff <= '0;
               if (div_cnt_ff == 5'(DIV_W - 1)) begin
                  state_ff <= (state_ff == ST_LK_DIV1) ? ST_LK_RESC : ST_LK_BLEND;
               end
            end
            ST_LK_RESC: begin
               s_ff <= s_in;
               state_ff <= ST_LK_CHECK;
            end
            ST_LK_CHECK: begin
               if (s_ff <= S_W'(pf_ff)) begin
                  res_col_ff <= prev_col_ff;
                  state_ff <= ST_EMIT;
               end else begin
                  idx_ff <= CNT_W'(1);
                  state_ff <= ST_LK_SCAN;
               end
            end
            ST_LK_SCAN: begin
               if (idx_ff < count_ff) begin
                  if (rd_pos_ext > s_ff) begin
                     ca_ff <= prev_col_ff;
                     cb_ff <= rd_col;
                     div_quo_ff <= {sp_diff[15:0], 16'h0000};
                     div_den_ff <= den17[DEN_W-1:0];
                     div_rem_ff <= '0;
                     div_cnt_ff <= '0;
                     state_ff <= ST_LK_DIV2;
                  end else begin
                     prev_pos_ff <= rd_pos;
                     prev_col_ff <= rd_col;
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else begin
                  res_col_ff <= prev_col_ff;
                  state_ff <= ST_EMIT;
               end
            end
            ST_LK_BLEND: begin
               res_col_ff[ch_ff*8 +: 8] <= blend_sum[23:16];
               ch_ff <= ch_ff + 1'b1;
               if (ch_ff == 2'd3) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= '{out_red: res_col_ff[7:0], out_green: res_col_ff[15:8],
                                   out_blue: res_col_ff[23:16],
                                   out_alpha: res_col_ff[31:24], status: res_status_ff};
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CMI_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "block still ready after accepting an item")
   `CMI_ASSERT(a_count_step, clock, reset, (count_ff != $past(count_ff)) |-> (count_ff == '0 || count_ff == $past(count_ff) + 1'b1), "key count moved by more than one")
   `CMI_ASSERT(a_result_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT, "result raised outside the emit step")
   `CMI_ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_W'(MAX_KEYS) && req_ready, "key count beyond table size")
endmodule
`default_nettype wire
